@@ rtl/cbhcp_pkg.sv @@
// Shared types, command codes and lookup functions for the host command parser.
// No dependencies; every other file refers to this package by scoped names.
package cbhcp_pkg;

    // framing bytes
    localparam logic [7:0] SOF_BYTE  = 8'hF1;
    localparam logic [7:0] EOF_BYTE  = 8'h00;

    // host command codes
    localparam logic [7:0] CMD_CAN_TX    = 8'h00;
    localparam logic [7:0] CMD_TIME      = 8'h01;
    localparam logic [7:0] CMD_BUS_SETUP = 8'h05;
    localparam logic [7:0] CMD_BUS_CFG   = 8'h06;
    localparam logic [7:0] CMD_DEV_INFO  = 8'h07;
    localparam logic [7:0] CMD_KEEPALIVE = 8'h09;
    localparam logic [7:0] CMD_BUS_COUNT = 8'h0C;

    // payload bytes that any command ever reads: id (4), dlc (1), data (8)
    localparam int PAY_USED = 13;

    // depth of the job queue between front and back
    localparam int JOB_Q_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_CMD,
        PH_PAY
    } t_phase;

    typedef enum logic [2:0] {
        OP_TIME,
        OP_BUS_CFG,
        OP_DEV_INFO,
        OP_KEEPALIVE,
        OP_BUS_COUNT,
        OP_CAN_TX
    } t_op;

    typedef enum logic [1:0] {
        RATE_125K,
        RATE_250K,
        RATE_500K,
        RATE_1M
    } t_rate;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_us;
    } t_rx_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  host_byte;
        logic        last;
        logic [30:0] tx_ident;
        logic        tx_extended;
        logic [3:0]  tx_length;
        logic [63:0] tx_bytes;
        logic        bus_enabled;
        logic        listen_mode;
        logic [19:0] bit_rate;
    } t_result;

    // one classified command handed from front to back
    typedef struct packed {
        t_op         op;
        logic [31:0] word;     // time stamp, bitrate or CAN identifier
        logic [3:0]  dlc;
        logic [63:0] data;
        logic        bus_on;
        logic        listen;
        t_rate       rate;
    } t_job;

    function automatic logic [19:0] rate_value(input t_rate code);
        logic [19:0] v;
        unique case (code)
            RATE_125K: v = 20'd125000;
            RATE_250K: v = 20'd250000;
            RATE_500K: v = 20'd500000;
            RATE_1M:   v = 20'd1000000;
            default:   v = 20'd500000;
        endcase
        return v;
    endfunction

    // unsupported bitrates snap to 500000
    function automatic t_rate rate_code_of(input logic [28:0] spd);
        t_rate c;
        priority if (spd == 29'd125000)  c = RATE_125K;
        else if (spd == 29'd250000)      c = RATE_250K;
        else if (spd == 29'd1000000)     c = RATE_1M;
        else                             c = RATE_500K;
        return c;
    endfunction

    function automatic logic [7:0] reply_cmd(input t_op op);
        logic [7:0] c;
        unique case (op)
            OP_TIME:      c = CMD_TIME;
            OP_BUS_CFG:   c = CMD_BUS_CFG;
            OP_DEV_INFO:  c = CMD_DEV_INFO;
            OP_KEEPALIVE: c = CMD_KEEPALIVE;
            OP_BUS_COUNT: c = CMD_BUS_COUNT;
            default:      c = CMD_CAN_TX;
        endcase
        return c;
    endfunction

    // index of the closing 00 in a reply: payload length plus two
    function automatic logic [3:0] reply_last_idx(input t_op op);
        logic [3:0] n;
        unique case (op)
            OP_TIME:      n = 4'd6;
            OP_BUS_CFG:   n = 4'd7;
            OP_DEV_INFO:  n = 4'd8;
            OP_KEEPALIVE: n = 4'd4;
            OP_BUS_COUNT: n = 4'd3;
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] j);
        logic [7:0] b;
        unique case (j)
            2'd0:    b = w[7:0];
            2'd1:    b = w[15:8];
            2'd2:    b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] reply_payload(input t_job job, input logic [2:0] j);
        logic [7:0] b;
        logic [2:0] jm1;
        jm1 = j - 3'd1;
        unique case (job.op)
            OP_TIME:      b = word_byte(job.word, j[1:0]);
            OP_BUS_CFG:   b = (j == 3'd0) ? {3'b000, job.listen, 3'b000, job.bus_on}
                                          : word_byte(job.word, jm1[1:0]);
            OP_DEV_INFO:  b = (j == 3'd0 || j == 3'd2) ? 8'h01 : 8'h00;
            OP_KEEPALIVE: b = (j == 3'd0) ? 8'hDE : 8'hAD;
            OP_BUS_COUNT: b = 8'h01;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/cbhcp_front.sv @@
// Front end: deframes host bytes, holds the payload and the bus setup, and
// classifies each finished frame into a job. Depends on cbhcp_pkg.
module cbhcp_front #(
    parameter int PAYLOAD_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cbhcp_pkg::t_rx_item i_item,
    output logic                o_job_push,
    output cbhcp_pkg::t_job     o_job
);

    localparam int CW    = $clog2(PAYLOAD_DEPTH + 1);
    localparam int NKEEP = (PAYLOAD_DEPTH < cbhcp_pkg::PAY_USED) ? PAYLOAD_DEPTH
                                                                  : cbhcp_pkg::PAY_USED;
    localparam int IW    = $clog2(NKEEP);

    cbhcp_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_cmd, n_cmd;
    logic [CW-1:0]     r_count, n_count;
    logic [7:0]        r_pay [NKEEP];
    logic              r_bus_on, n_bus_on;
    logic              r_listen, n_listen;
    cbhcp_pkg::t_rate  r_rate, n_rate;

    logic [7:0]  pay [cbhcp_pkg::PAY_USED];
    logic [31:0] word0;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic        frame_end;
    logic        pay_wr;

    // payload bytes as the commands see them: zero past the received count
    for (genvar i = 0; i < cbhcp_pkg::PAY_USED; i++) begin : g_pay
        if (i < NKEEP) begin : g_kept
            assign pay[i] = (CW'(i) < r_count) ? r_pay[i] : 8'h00;
        end else begin : g_zero
            assign pay[i] = 8'h00;
        end
    end

    assign word0 = {pay[3], pay[2], pay[1], pay[0]};
    assign dlc   = (pay[4][3:0] > 4'd8) ? 4'd8 : pay[4][3:0];

    for (genvar i = 0; i < 8; i++) begin : g_data
        assign data[8*i +: 8] = (4'(i) < dlc) ? pay[5+i] : 8'h00;
    end

    assign frame_end = i_valid && (r_phase == cbhcp_pkg::PH_PAY)
                       && (i_item.rx_byte == cbhcp_pkg::EOF_BYTE);
    assign pay_wr    = i_valid && (r_phase == cbhcp_pkg::PH_PAY)
                       && (i_item.rx_byte != cbhcp_pkg::EOF_BYTE)
                       && (r_count < CW'(PAYLOAD_DEPTH));

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_valid) begin
            unique case (r_phase)
                cbhcp_pkg::PH_WAIT: begin
                    if (i_item.rx_byte == cbhcp_pkg::SOF_BYTE) n_phase = cbhcp_pkg::PH_CMD;
                end
                cbhcp_pkg::PH_CMD: begin
                    n_phase = cbhcp_pkg::PH_PAY;
                end
                cbhcp_pkg::PH_PAY: begin
                    if (i_item.rx_byte == cbhcp_pkg::EOF_BYTE) n_phase = cbhcp_pkg::PH_WAIT;
                end
                default: n_phase = cbhcp_pkg::PH_WAIT;
            endcase
        end
    end

    // outputs and data registers
    always_comb begin
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_bus_on   = r_bus_on;
        n_listen   = r_listen;
        n_rate     = r_rate;
        o_job_push = 1'b0;
        o_job.op     = cbhcp_pkg::OP_CAN_TX;
        o_job.word   = i_item.now_us;
        o_job.dlc    = dlc;
        o_job.data   = data;
        o_job.bus_on = r_bus_on;
        o_job.listen = r_listen;
        o_job.rate   = r_rate;

        if (i_valid && r_phase == cbhcp_pkg::PH_CMD) begin
            n_cmd   = i_item.rx_byte;
            n_count = '0;
        end
        if (pay_wr) n_count = r_count + CW'(1);

        if (frame_end) begin
            unique case (r_cmd)
                cbhcp_pkg::CMD_TIME: begin
                    o_job_push = 1'b1;
                    o_job.op   = cbhcp_pkg::OP_TIME;
                end
                cbhcp_pkg::CMD_BUS_CFG: begin
                    o_job_push = 1'b1;
                    o_job.op   = cbhcp_pkg::OP_BUS_CFG;
                    o_job.word = 32'(cbhcp_pkg::rate_value(r_rate));
                end
                cbhcp_pkg::CMD_DEV_INFO: begin
                    o_job_push = 1'b1;
                    o_job.op   = cbhcp_pkg::OP_DEV_INFO;
                end
                cbhcp_pkg::CMD_KEEPALIVE: begin
                    o_job_push = 1'b1;
                    o_job.op   = cbhcp_pkg::OP_KEEPALIVE;
                end
                cbhcp_pkg::CMD_BUS_COUNT: begin
                    o_job_push = 1'b1;
                    o_job.op   = cbhcp_pkg::OP_BUS_COUNT;
                end
                cbhcp_pkg::CMD_CAN_TX: begin
                    o_job_push = (r_count >= CW'(5));
                    o_job.op   = cbhcp_pkg::OP_CAN_TX;
                    o_job.word = word0;
                end
                cbhcp_pkg::CMD_BUS_SETUP: begin
                    // apply only when the enable-change flag is set
                    if (r_count >= CW'(4) && word0[31]) begin
                        if (!word0[30]) begin
                            n_bus_on = 1'b0;
                        end else begin
                            n_bus_on = 1'b1;
                            n_listen = word0[29];
                            n_rate   = cbhcp_pkg::rate_code_of(word0[28:0]);
                        end
                    end
                end
                default: o_job_push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cbhcp_pkg::PH_WAIT;
            r_cmd    <= '0;
            r_count  <= '0;
            r_bus_on <= 1'b1;
            r_listen <= 1'b0;
            r_rate   <= cbhcp_pkg::RATE_500K;
        end else begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_count  <= n_count;
            r_bus_on <= n_bus_on;
            r_listen <= n_listen;
            r_rate   <= n_rate;
        end
    end

    // keep only the bytes any command reads
    always_ff @(posedge i_clk) begin
        if (pay_wr && r_count < CW'(NKEEP)) begin
            r_pay[r_count[IW-1:0]] <= i_item.rx_byte;
        end
    end

endmodule

@@ rtl/cbhcp_job_fifo.sv @@
// Short job queue between the front end and the back end.
// Depends on cbhcp_pkg for the job type and the queue depth.
module cbhcp_job_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cbhcp_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cbhcp_pkg::t_job o_job
);

    localparam int DEPTH = cbhcp_pkg::JOB_Q_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    cbhcp_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        if (do_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        if (do_push && !do_pop) n_cnt = r_cnt + NW'(1);
        else if (do_pop && !do_push) n_cnt = r_cnt - NW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

@@ rtl/cbhcp_back.sv @@
// Back end: walks each job out as reply bytes or one CAN transmit request
// into a registered result stage. Depends on cbhcp_pkg.
module cbhcp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  cbhcp_pkg::t_job   i_job,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output cbhcp_pkg::t_result o_result
);

    logic               r_out_valid;
    cbhcp_pkg::t_result r_out, n_out;
    logic [3:0]         r_idx, n_idx;
    logic [3:0]         last_idx;
    logic [3:0]         pay_idx;
    logic               load;
    logic               is_last;

    assign load     = i_job_valid && (!r_out_valid || i_pop);
    assign last_idx = cbhcp_pkg::reply_last_idx(i_job.op);
    assign is_last  = (i_job.op == cbhcp_pkg::OP_CAN_TX) || (r_idx == last_idx);
    assign pay_idx  = r_idx - 4'd2;

    assign o_job_pop = load && is_last;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        n_out             = '0;
        n_out.last        = is_last;
        n_out.bus_enabled = i_job.bus_on;
        n_out.listen_mode = i_job.listen;
        n_out.bit_rate    = cbhcp_pkg::rate_value(i_job.rate);
        if (i_job.op == cbhcp_pkg::OP_CAN_TX) begin
            n_out.kind        = 1'b1;
            n_out.tx_ident    = i_job.word[30:0];
            n_out.tx_extended = i_job.word[31];
            n_out.tx_length   = i_job.dlc;
            n_out.tx_bytes    = i_job.data;
        end else begin
            priority if (r_idx == 4'd0) n_out.host_byte = cbhcp_pkg::SOF_BYTE;
            else if (r_idx == 4'd1)     n_out.host_byte = cbhcp_pkg::reply_cmd(i_job.op);
            else if (is_last)           n_out.host_byte = cbhcp_pkg::EOF_BYTE;
            else n_out.host_byte = cbhcp_pkg::reply_payload(i_job, pay_idx[2:0]);
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (load) n_idx = is_last ? 4'd0 : r_idx + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_out;
    end

endmodule

@@ rtl/can_bridge_host_command_parser_top.sv @@
// Top level of the host command parser: front end, job queue, back end.
// Depends on cbhcp_pkg, cbhcp_front, cbhcp_job_fifo and cbhcp_back.
//
// Input channel: one host serial byte with its microsecond time stamp per
// word, taken when i_push is high and o_full is low. Frames are F1, command,
// payload, 00; the closing 00 triggers the command.
// Result channel: o_result holds the oldest result while o_empty is low; it
// is taken when i_pop is high. A reply is a run of host bytes (last set on
// the closing 00); a transmit request is one word with kind set.
// A frame's job is queued when its closing 00 is taken, then loaded into the
// registered result stage. One input word per cycle while o_full is low, one
// result per cycle while i_pop is high; a reply occupies the back end until its closing 00.
// o_full rises only when the two-entry job queue is full, i.e. while replies
// drain more slowly than frames arrive; input words are never held otherwise.
// A stalled receiver holds the output word and the back end.
// Reset (synchronous, active low) empties the queue and output stage, waits
// for a start byte, and sets the bus on, not listen-only, at 500000 bit/s.
module can_bridge_host_command_parser_top #(
    parameter int PAYLOAD_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  cbhcp_pkg::t_rx_item i_item,
    input  logic                i_pop,
    output logic                o_empty,
    output cbhcp_pkg::t_result  o_result
);

    logic            accept;
    logic            job_push;
    cbhcp_pkg::t_job job_in;
    cbhcp_pkg::t_job job_head;
    logic            job_empty;
    logic            job_pop;

    assign accept = i_push && !o_full;

    cbhcp_front #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    cbhcp_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (o_full),
        .o_empty (job_empty),
        .o_job   (job_head)
    );

    cbhcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );

endmodule
